// ----- hw/rtl/dhpd_pkg.sv -----
package dhpd_pkg;

    // Number of pad channels held in the per-channel state
    localparam int CHANNELS = 16;
    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Field widths
    localparam int CH_W     = 4;
    localparam int SMP_W    = 16;
    localparam int VEL_W    = 12;
    localparam int CNT_W    = 8;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Stream widths, padded to whole bytes
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HIGH_THRESHOLD  = 2'd0,
        CFG_LOW_THRESHOLD   = 2'd1,
        CFG_HOLDOFF_SAMPLES = 2'd2
    } t_cfg_idx;

    // Register reset values
    localparam logic signed [SMP_W-1:0] HIGH_THRESHOLD_RST  = 16'sd2000;
    localparam logic signed [SMP_W-1:0] LOW_THRESHOLD_RST   = 16'sd5;
    localparam logic        [CNT_W-1:0] HOLDOFF_SAMPLES_RST = 8'd5;

    typedef struct packed {
        logic signed [SMP_W-1:0] high_threshold;
        logic signed [SMP_W-1:0] low_threshold;
        logic        [CNT_W-1:0] holdoff_samples;
    } t_cfg;

    typedef struct packed {
        logic                    hit;
        logic        [CH_W-1:0]  hit_channel;
        logic signed [VEL_W-1:0] velocity;
        logic                    is_active;
    } t_result;

endpackage

// ----- hw/rtl/dhpd_cfg_regs.sv -----
module dhpd_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dhpd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dhpd_pkg::CFG_W-1:0]      i_cfg_data,
    output dhpd_pkg::t_cfg                  o_cfg
);

    dhpd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_threshold  <= dhpd_pkg::HIGH_THRESHOLD_RST;
            r_cfg.low_threshold   <= dhpd_pkg::LOW_THRESHOLD_RST;
            r_cfg.holdoff_samples <= dhpd_pkg::HOLDOFF_SAMPLES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dhpd_pkg::CFG_HIGH_THRESHOLD:  r_cfg.high_threshold  <= $signed(i_cfg_data);
                dhpd_pkg::CFG_LOW_THRESHOLD:   r_cfg.low_threshold   <= $signed(i_cfg_data);
                dhpd_pkg::CFG_HOLDOFF_SAMPLES:
                    r_cfg.holdoff_samples <= i_cfg_data[dhpd_pkg::CNT_W-1:0];
                default: ;  // unused index: drop the write
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hw/rtl/dhpd_chan_state.sv -----
module dhpd_chan_state (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_upd,
    input  logic [dhpd_pkg::CH_W-1:0]           i_ch,
    input  logic signed [dhpd_pkg::SMP_W-1:0]   i_sample,
    input  dhpd_pkg::t_cfg                      i_cfg,
    output dhpd_pkg::t_result                   o_res
);

    logic                               r_act  [dhpd_pkg::CHANNELS];
    logic [dhpd_pkg::CNT_W-1:0]         r_cnt  [dhpd_pkg::CHANNELS];
    logic signed [dhpd_pkg::SMP_W-1:0]  r_prev [dhpd_pkg::CHANNELS];

    logic                               ch_ok;
    logic [dhpd_pkg::IDX_W-1:0]         idx;
    logic                               cur_act;
    logic [dhpd_pkg::CNT_W-1:0]         cur_cnt;
    logic signed [dhpd_pkg::SMP_W-1:0]  cur_prev;
    logic [dhpd_pkg::CNT_W-1:0]         cnt_dec;
    logic                               hit;
    logic                               n_act;
    logic [dhpd_pkg::CNT_W-1:0]         n_cnt;

    assign ch_ok = (32'(i_ch) < dhpd_pkg::CHANNELS);
    assign idx   = dhpd_pkg::IDX_W'(i_ch);

    always_comb begin
        cur_act  = ch_ok ? r_act[idx]  : 1'b0;
        cur_cnt  = ch_ok ? r_cnt[idx]  : '0;
        cur_prev = ch_ok ? r_prev[idx] : '0;
        cnt_dec  = (cur_cnt != '0) ? cur_cnt - 1'b1 : '0;
        hit      = 1'b0;
        n_act    = cur_act;
        n_cnt    = cur_cnt;
        if (!cur_act && i_sample >= i_cfg.high_threshold && i_sample < cur_prev) begin
            // falling edge past the peak: fire
            hit   = ch_ok;
            n_act = 1'b1;
            n_cnt = i_cfg.holdoff_samples;
        end else if (cur_act && i_sample >= i_cfg.low_threshold) begin
            n_cnt = i_cfg.holdoff_samples;
        end else if (cur_act) begin
            n_cnt = cnt_dec;
            n_act = (cnt_dec != '0);
        end
        o_res.hit         = hit;
        o_res.hit_channel = i_ch;
        o_res.velocity    = hit ? i_sample[dhpd_pkg::SMP_W-1:4] : '0;
        o_res.is_active   = ch_ok & n_act;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < dhpd_pkg::CHANNELS; i++) begin
                r_act[i]  <= 1'b0;
                r_cnt[i]  <= '0;
                r_prev[i] <= '0;
            end
        end else if (i_upd && ch_ok) begin
            r_act[idx]  <= n_act;
            r_cnt[idx]  <= n_cnt;
            r_prev[idx] <= i_sample;
        end
    end

endmodule

// ----- hw/rtl/drum_hit_peak_detector_unit.sv -----
// The result of an accepted sample passes the input register, then the result
//   register, before it is offered on the master side.
// Throughput: one sample per cycle while the master side accepts results; the
//   per-channel state is read and written back in the same cycle, so
//   consecutive samples of one channel chain freely.
// Reset (synchronous, active low): thresholds and holdoff return to 2000/5/5,
//   all channels idle with zero count and zero previous sample, pipeline empty.
module drum_hit_peak_detector_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // sample stream in
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [dhpd_pkg::S_TDATA_W-1:0]       i_s_tdata,  // [3:0] channel, [19:4] sample
    // result stream out
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [dhpd_pkg::M_TDATA_W-1:0]       o_m_tdata,  // [3:0] hit_channel,
                                                             // [15:4] velocity, [16] is_active
    output logic                                 o_m_tuser,  // [0] hit
    // configuration writes
    input  logic                                 i_cfg_we,
    input  logic [dhpd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [dhpd_pkg::CFG_W-1:0]           i_cfg_data
);

    dhpd_pkg::t_cfg     cfg;
    dhpd_pkg::t_result  res;

    // Input register
    logic                               r_in_vld;
    logic [dhpd_pkg::CH_W-1:0]          r_in_ch;
    logic signed [dhpd_pkg::SMP_W-1:0]  r_in_smp;

    // Result register
    logic                               r_out_vld;
    dhpd_pkg::t_result                  r_out;

    logic advance;   // the input stage moves into the result register
    logic s_xfer;

    dhpd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Result register frees when empty or when its transfer completes this cycle
    assign advance    = !r_out_vld || i_m_tready;
    // Input register frees when empty or when it advances
    assign o_s_tready = !r_in_vld || advance;
    assign s_xfer     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_in_ch  <= i_s_tdata[dhpd_pkg::CH_W-1:0];
            r_in_smp <= $signed(i_s_tdata[dhpd_pkg::CH_W+dhpd_pkg::SMP_W-1:dhpd_pkg::CH_W]);
        end
    end

    // Compare, update the channel state, and form the result in one pass
    dhpd_chan_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_upd    (r_in_vld && advance),
        .i_ch     (r_in_ch),
        .i_sample (r_in_smp),
        .i_cfg    (cfg),
        .o_res    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_vld) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tuser  = r_out.hit;
    assign o_m_tdata  = dhpd_pkg::M_TDATA_W'({r_out.is_active, r_out.velocity,
                                              r_out.hit_channel});

    // A hit always leaves its channel active
    a_hit_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.hit |-> r_out.is_active)
        else $error("hit reported on an inactive channel");

    // Velocity is zero without a hit
    a_vel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out.hit |-> r_out.velocity == '0)
        else $error("nonzero velocity without hit");

    // A held input item stays put while the result side stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !advance |=> r_in_vld && $stable(r_in_ch) && $stable(r_in_smp))
        else $error("input stage lost an item under stall");

    // Reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_vld && !r_in_vld)
        else $error("pipeline not empty after reset");

endmodule

// ----- bench/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Receiver back-pressure shapes, switched between phases
    typedef enum int {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_PERIODIC,
        RDY_BURSTY
    } t_rdy_mode;

    logic                               i_clk      = 1'b0;
    logic                               i_rst_n    = 1'b0;
    logic                               i_s_tvalid = 1'b0;
    logic                               o_s_tready;
    logic [dhpd_pkg::S_TDATA_W-1:0]     i_s_tdata  = '0;    // [3:0] channel, [19:4] sample
    logic                               o_m_tvalid;
    logic                               i_m_tready = 1'b0;
    logic [dhpd_pkg::M_TDATA_W-1:0]     o_m_tdata;          // [3:0] hit_channel,
                                                            // [15:4] velocity, [16] is_active
    logic                               o_m_tuser;          // [0] hit
    logic                               i_cfg_we   = 1'b0;
    logic [dhpd_pkg::CFG_IDX_W-1:0]     i_cfg_idx  = dhpd_pkg::CFG_HIGH_THRESHOLD;
    logic [dhpd_pkg::CFG_W-1:0]         i_cfg_data = '0;

    drum_hit_peak_detector_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow of the block: register copies and per-pad state
    logic signed [dhpd_pkg::SMP_W-1:0] thr_high;
    logic signed [dhpd_pkg::SMP_W-1:0] thr_low;
    logic        [dhpd_pkg::CNT_W-1:0] holdoff_len;
    logic                              pad_active [dhpd_pkg::CHANNELS];
    logic        [dhpd_pkg::CNT_W-1:0] pad_count  [dhpd_pkg::CHANNELS];
    logic signed [dhpd_pkg::SMP_W-1:0] pad_prev   [dhpd_pkg::CHANNELS];

    // Results still owed by the block, oldest first
    dhpd_pkg::t_result pad_results [$];

    // Per-channel envelope generator for well-formed strikes
    int env_stage [dhpd_pkg::CHANNELS];
    int env_level [dhpd_pkg::CHANNELS];
    int env_quiet [dhpd_pkg::CHANNELS];

    t_rdy_mode rdy_mode = RDY_RANDOM;
    int        rdy_tick = 0;
    int        stall_left = 0;
    int        burst_left = 1;
    int        gap_left = 0;

    int err_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int hits_seen = 0;
    int releases_seen = 0;
    int phases_run = 0;

    // Work out one result and advance the shadow state of that pad.
    function automatic dhpd_pkg::t_result predict_pad(
        input logic [dhpd_pkg::CH_W-1:0]          ch,
        input logic signed [dhpd_pkg::SMP_W-1:0]  smp);
        dhpd_pkg::t_result                 r;
        logic signed [dhpd_pkg::SMP_W-1:0] shifted;
        r = '0;
        r.hit_channel = ch;
        if (int'(ch) < dhpd_pkg::CHANNELS) begin
            if (!pad_active[ch] && smp >= thr_high && smp < pad_prev[ch]) begin
                // Peak has passed above the trigger level: fire and arm holdoff
                pad_active[ch] = 1'b1;
                pad_count[ch]  = holdoff_len;
                shifted        = smp >>> 4;
                r.hit          = 1'b1;
                r.velocity     = shifted[dhpd_pkg::VEL_W-1:0];
            end else if (pad_active[ch] && smp >= thr_low) begin
                // Still ringing: restart the quiet count
                pad_count[ch] = holdoff_len;
            end else if (pad_active[ch]) begin
                // Quiet sample: count down, floor at zero, release on zero
                if (pad_count[ch] != '0)
                    pad_count[ch] = pad_count[ch] - 1'b1;
                if (pad_count[ch] == '0) begin
                    pad_active[ch] = 1'b0;
                    releases_seen++;
                end
            end
            pad_prev[ch] = smp;
            r.is_active  = pad_active[ch];
        end
        return r;
    endfunction

    function automatic logic signed [dhpd_pkg::SMP_W-1:0] to_sample(input int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return v[dhpd_pkg::SMP_W-1:0];
    endfunction

    // Receiver: each mode sets ready on its own pattern; RDY_ALWAYS never stalls
    always @(posedge i_clk) begin
        rdy_tick <= rdy_tick + 1;
        case (rdy_mode)
            RDY_ALWAYS: begin
                i_m_tready <= 1'b1;
            end
            RDY_RANDOM: begin
                i_m_tready <= ($urandom_range(99, 0) < 65);
            end
            RDY_PERIODIC: begin
                i_m_tready <= ((rdy_tick % 11) > 3);
            end
            default: begin
                // Mostly open, with occasional long stalls
                if (stall_left > 0) begin
                    stall_left <= stall_left - 1;
                    i_m_tready <= 1'b0;
                end else if ($urandom_range(99, 0) < 6) begin
                    stall_left <= $urandom_range(20, 4);
                    i_m_tready <= 1'b0;
                end else begin
                    i_m_tready <= 1'b1;
                end
            end
        endcase
    end

    // Compare every result transfer against the oldest prediction
    always @(posedge i_clk) begin
        dhpd_pkg::t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pad_results.size() == 0) begin
                $error("unexpected result transfer: tdata 0x%06h tuser %0b",
                       o_m_tdata, o_m_tuser);
                err_count++;
            end else begin
                want = pad_results.pop_front();
                results_checked++;
                if (o_m_tuser)
                    hits_seen++;
                if (o_m_tuser !== want.hit) begin
                    $error("hit: expected %0d, actual %0d", want.hit, o_m_tuser);
                    err_count++;
                end
                if (o_m_tdata[3:0] !== want.hit_channel) begin
                    $error("hit_channel: expected %0d, actual %0d",
                           want.hit_channel, o_m_tdata[3:0]);
                    err_count++;
                end
                if (o_m_tdata[15:4] !== want.velocity) begin
                    $error("velocity: expected %0d, actual %0d",
                           $signed(want.velocity), $signed(o_m_tdata[15:4]));
                    err_count++;
                end
                if (o_m_tdata[16] !== want.is_active) begin
                    $error("is_active: expected %0d, actual %0d",
                           want.is_active, o_m_tdata[16]);
                    err_count++;
                end
            end
        end
    end

    // Offer one sample, hold it until the transfer, then predict its result.
    // The sender runs in bursts; gaps are inserted ahead of a burst.
    task automatic send_sample(input logic [dhpd_pkg::CH_W-1:0] ch,
                               input logic signed [dhpd_pkg::SMP_W-1:0] smp);
        while (gap_left > 0) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= dhpd_pkg::S_TDATA_W'($urandom);
            @(posedge i_clk);
            gap_left--;
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(dhpd_pkg::S_TDATA_W - dhpd_pkg::CH_W - dhpd_pkg::SMP_W){1'b0}},
                       smp, ch};
        do
            @(posedge i_clk);
        while (!o_s_tready);
        pad_results.push_back(predict_pad(ch, smp));
        items_sent++;
        if (burst_left > 1) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(24, 1);
            gap_left   = ($urandom_range(9, 0) < 4) ? 0 : $urandom_range(6, 1);
        end
    endtask

    // Drop valid, then wait out every owed result plus the pipeline depth
    task automatic drain_stream();
        i_s_tvalid <= 1'b0;
        while (pad_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input dhpd_pkg::t_cfg_idx idx,
                             input logic [dhpd_pkg::CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            dhpd_pkg::CFG_HIGH_THRESHOLD:  thr_high    = val;
            dhpd_pkg::CFG_LOW_THRESHOLD:   thr_low     = val;
            dhpd_pkg::CFG_HOLDOFF_SAMPLES: holdoff_len = val[dhpd_pkg::CNT_W-1:0];
            default: ;
        endcase
    endtask

    // Start a phase: block idle, all three registers rewritten, new receiver shape
    task automatic start_phase(input logic signed [dhpd_pkg::SMP_W-1:0] hi,
                               input logic signed [dhpd_pkg::SMP_W-1:0] lo,
                               input logic [dhpd_pkg::CNT_W-1:0] hold,
                               input t_rdy_mode mode);
        drain_stream();
        write_reg(dhpd_pkg::CFG_HIGH_THRESHOLD, hi);
        write_reg(dhpd_pkg::CFG_LOW_THRESHOLD, lo);
        write_reg(dhpd_pkg::CFG_HOLDOFF_SAMPLES,
                  {{(dhpd_pkg::CFG_W - dhpd_pkg::CNT_W){1'b0}}, hold});
        rdy_mode = mode;
        phases_run++;
    endtask

    // Next point of a strike envelope: rise past the trigger level, fall
    // (with small bounces that keep holdoff busy), then a quiet tail.
    task automatic next_pad_sample(input int ch,
                                   output logic signed [dhpd_pkg::SMP_W-1:0] smp);
        int span;
        int lvl;
        span = (int'(thr_high) - int'(thr_low)) / 2;
        if (span < 16)
            span = 16;
        lvl = env_level[ch];
        case (env_stage[ch])
            0: begin
                lvl = lvl + int'($urandom_range(span, 1));
                if (lvl >= int'(thr_high) || lvl >= 32767)
                    env_stage[ch] = 1;
            end
            1: begin
                if ($urandom_range(99, 0) < 20)
                    lvl = lvl + int'($urandom_range(span / 4, 0));
                else
                    lvl = lvl - int'($urandom_range(span, 1));
                if (lvl < int'(thr_low) || lvl <= -32768) begin
                    env_stage[ch] = 2;
                    env_quiet[ch] = $urandom_range(int'(holdoff_len) + 2, 0);
                end
            end
            default: begin
                if ($urandom_range(99, 0) < 10)
                    lvl = int'(thr_low) + int'($urandom_range(200, 0));
                else
                    lvl = int'(thr_low) - int'($urandom_range(300, 1));
                if (env_quiet[ch] == 0)
                    env_stage[ch] = 0;
                else
                    env_quiet[ch]--;
            end
        endcase
        smp = to_sample(lvl);
        env_level[ch] = int'(smp);
    endtask

    // Mostly strikes on a few busy pads, some on any pad, the rest raw noise
    task automatic run_random_pads(input int n, input int noise_pct);
        int                                ch;
        int                                focus [4];
        logic signed [dhpd_pkg::SMP_W-1:0] smp;
        foreach (focus[k])
            focus[k] = $urandom_range(dhpd_pkg::CHANNELS - 1, 0);
        for (int c = 0; c < dhpd_pkg::CHANNELS; c++) begin
            env_stage[c] = 0;
            env_level[c] = int'(pad_prev[c]);
            env_quiet[c] = 0;
        end
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99, 0) < noise_pct) begin
                ch  = $urandom_range(dhpd_pkg::CHANNELS - 1, 0);
                smp = dhpd_pkg::SMP_W'($urandom);
            end else begin
                ch = ($urandom_range(3, 0) == 0) ? $urandom_range(dhpd_pkg::CHANNELS - 1, 0)
                                                 : focus[$urandom_range(3, 0)];
                next_pad_sample(ch, smp);
            end
            send_sample(ch[dhpd_pkg::CH_W-1:0], smp);
        end
    endtask

    // Reset values: rising edge no hit, falling edge hits, a loud sample
    // reloads holdoff, five quiet samples release; trigger exactly at level.
    task automatic test_basic_strike();
        start_phase(dhpd_pkg::HIGH_THRESHOLD_RST, dhpd_pkg::LOW_THRESHOLD_RST,
                    dhpd_pkg::HOLDOFF_SAMPLES_RST, RDY_RANDOM);
        send_sample(4'd0, 16'sd3000);
        send_sample(4'd0, 16'sd2500);
        send_sample(4'd0, 16'sd10);
        repeat (5) send_sample(4'd0, 16'sd0);
        send_sample(4'd15, 16'sd32767);
        send_sample(4'd15, 16'sd2000);
    endtask

    // Lowest trigger level, highest quiet level, zero holdoff: a hit loads
    // a zero count and the next quiet sample releases; negative velocity.
    task automatic test_zero_holdoff_extremes();
        start_phase(-16'sd32768, 16'sd32767, 8'd0, RDY_PERIODIC);
        send_sample(4'd3, -16'sd1);
        send_sample(4'd3, -16'sd32768);
        send_sample(4'd3, -16'sd32768);
    endtask

    // Full-scale peak gives the largest velocity; lowest quiet level reloads
    task automatic test_full_scale_peak();
        start_phase(16'sd32766, -16'sd32768, 8'd255, RDY_ALWAYS);
        send_sample(4'd7, 16'sd32767);
        send_sample(4'd7, 16'sd32766);
        send_sample(4'd7, -16'sd32768);
    endtask

    // Count of one: a single quiet sample counts it down to zero and releases
    task automatic test_count_floor();
        start_phase(16'sd100, 16'sd0, 8'd1, RDY_BURSTY);
        send_sample(4'd1, 16'sd200);
        send_sample(4'd1, 16'sd150);
        send_sample(4'd1, -16'sd5);
    endtask

    task automatic test_random_default();
        start_phase(dhpd_pkg::HIGH_THRESHOLD_RST, dhpd_pkg::LOW_THRESHOLD_RST,
                    dhpd_pkg::HOLDOFF_SAMPLES_RST, RDY_ALWAYS);
        run_random_pads(250, 10);
    endtask

    task automatic test_random_short_holdoff();
        start_phase(16'sd500, -16'sd300, 8'd2, RDY_RANDOM);
        run_random_pads(250, 10);
    endtask

    task automatic test_random_thresholds();
        logic signed [dhpd_pkg::SMP_W-1:0] hi;
        hi = to_sample(int'($urandom_range(20000, 0)) - 10000);
        start_phase(hi, to_sample(int'(hi) - int'($urandom_range(3000, 0))),
                    dhpd_pkg::CNT_W'($urandom_range(12, 0)), RDY_PERIODIC);
        run_random_pads(250, 15);
    endtask

    // Quiet level at its floor: pads never release once they fire
    task automatic test_random_saturated();
        start_phase(-16'sd20000, -16'sd32768, 8'd255, RDY_BURSTY);
        run_random_pads(100, 30);
    endtask

    task automatic test_random_noise();
        start_phase(dhpd_pkg::SMP_W'($urandom), dhpd_pkg::SMP_W'($urandom),
                    dhpd_pkg::CNT_W'($urandom_range(8, 0)), RDY_BURSTY);
        run_random_pads(250, 50);
    endtask

    initial begin
        thr_high    = dhpd_pkg::HIGH_THRESHOLD_RST;
        thr_low     = dhpd_pkg::LOW_THRESHOLD_RST;
        holdoff_len = dhpd_pkg::HOLDOFF_SAMPLES_RST;
        for (int c = 0; c < dhpd_pkg::CHANNELS; c++) begin
            pad_active[c] = 1'b0;
            pad_count[c]  = '0;
            pad_prev[c]   = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_strike();
        test_zero_holdoff_extremes();
        test_full_scale_peak();
        test_count_floor();
        test_random_default();
        test_random_short_holdoff();
        test_random_thresholds();
        test_random_saturated();
        test_random_noise();

        drain_stream();
        repeat (8) @(posedge i_clk);
        $display("%0d samples over %0d register settings, %0d results checked",
                 items_sent, phases_run, results_checked);
        $display("%0d hits fired, %0d holdoff releases", hits_seen, releases_seen);
        if (err_count == 0)
            $display("drum_hit_peak_detector_unit regression: pass");
        else
            $display("drum_hit_peak_detector_unit regression: fail");
        $finish;
    end

    // Hard stop far beyond the slowest legal run
    initial begin
        #(3_000_000);
        $display("timeout with %0d results still owed", pad_results.size());
        $display("drum_hit_peak_detector_unit regression: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/dhpd_pkg.sv
hw/rtl/dhpd_cfg_regs.sv
hw/rtl/dhpd_chan_state.sv
hw/rtl/drum_hit_peak_detector_unit.sv
bench/tb.sv
